// ----- design/spfp_pkg.sv -----
// Shared types, event codes and CRC helpers for the SPARTN frame parser.
// Used by spfp_front, spfp_queue and spartn_frame_parser; depends on nothing.
`timescale 1ns / 1ps

package spfp_pkg;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_PAYLOAD  = 3'd1;
    localparam logic [2:0] EV_HDR_FAIL = 3'd2;
    localparam logic [2:0] EV_CRC_OK   = 3'd3;
    localparam logic [2:0] EV_CRC_BAD  = 3'd4;
    localparam logic [2:0] EV_UNCHECK  = 3'd5;

    localparam logic [7:0]  SYNC_RESET = 8'd115;
    localparam logic [1:0]  CRC_TYPE_24 = 2'd2;
    localparam logic [24:0] CRC24_POLY = 25'h1864CFB;
    localparam int          QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [6:0]  msg_type;
        logic [3:0]  message_subtype;
        logic [9:0]  payload_length;
        logic [31:0] time_tag;
        logic        long_time_tag;
        logic [6:0]  soln_ident;
        logic [3:0]  processor_id;
        logic        encrypted;
        logic [3:0]  enc_ident;
        logic [5:0]  sequence_number;
    } result_t;

    // One byte of CRC-24Q, MSB first
    function automatic logic [23:0] crc24_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [24:0] c;
        c = {1'b0, crc ^ {b, 16'd0}};
        for (int i = 0; i < 8; i++) begin
            c = {c[23:0], 1'b0};
            if (c[24])
                c = c ^ CRC24_POLY;
        end
        return c[23:0];
    endfunction

    // One byte of CRC-4 (x^4+x+1), MSB first
    function automatic logic [3:0] crc4_byte(input logic [3:0] crc, input logic [7:0] b);
        logic [3:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[3] ^ b[i];
            c  = {c[2:0], 1'b0};
            if (fb)
                c = c ^ 4'h3;
        end
        return c;
    endfunction

    // Embedded authentication byte count for a length code
    function automatic logic [6:0] auth_len(input logic [2:0] code);
        logic [6:0] r;
        case (code)
            3'd0:    r = 7'd8;
            3'd1:    r = 7'd12;
            3'd2:    r = 7'd16;
            3'd3:    r = 7'd32;
            3'd4:    r = 7'd64;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/spfp_front.sv -----
// Front end: hunts the preamble, tracks frame position, checks the header CRC-4 and,
// for CRC-24 frames, the frame CRC, and builds one result per accepted byte. Depends on spfp_pkg.
`timescale 1ns / 1ps

module spfp_front
    import spfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] rx_byte,
    input  logic [7:0] sync_byte,
    output result_t    res
);

    logic [10:0] byte_count_reg, byte_count_next;
    logic [34:0] shift_reg, shift_next;
    logic [6:0]  type_reg, type_next;
    logic [9:0]  length_reg, length_next;
    logic        eaf_reg, eaf_next;
    logic [1:0]  crct_reg, crct_next;
    logic        tt_reg, tt_next;
    logic [3:0]  sub_reg, sub_next;
    logic [6:0]  sol_reg, sol_next;
    logic [3:0]  proc_reg, proc_next;
    logic [3:0]  enc_reg, enc_next;
    logic [5:0]  seq_reg, seq_next;
    logic [2:0]  ai_reg, ai_next;
    logic [2:0]  eal_reg, eal_next;
    logic [31:0] time_reg, time_next;
    logic [23:0] crc_reg, crc_next;
    logic [3:0]  crc4_reg, crc4_next;
    logic [23:0] rcv_reg, rcv_next;

    logic [10:0] n, hdr_end, ea_end, pay_end, auth_end, crc_end;
    logic [42:0] hs;

    // Frame layout for the current byte
    always_comb
    begin
        n        = byte_count_reg + 11'd1;
        hs       = {shift_reg, rx_byte};
        hdr_end  = tt_reg ? 11'd10 : 11'd8;
        ea_end   = hdr_end + (eaf_reg ? 11'd2 : 11'd0);
        pay_end  = ea_end + {1'b0, length_reg};
        auth_end = pay_end + ((eaf_reg && ai_reg > 3'd1) ? {4'd0, auth_len(eal_reg)} : 11'd0);
        crc_end  = auth_end + {9'd0, crct_reg} + 11'd1;
    end

    // Advance the frame state and build the result
    always_comb
    begin
        byte_count_next = byte_count_reg;
        shift_next  = shift_reg;
        type_next   = type_reg;
        length_next = length_reg;
        eaf_next    = eaf_reg;
        crct_next   = crct_reg;
        tt_next     = tt_reg;
        sub_next    = sub_reg;
        sol_next    = sol_reg;
        proc_next   = proc_reg;
        enc_next    = enc_reg;
        seq_next    = seq_reg;
        ai_next     = ai_reg;
        eal_next    = eal_reg;
        time_next   = time_reg;
        crc_next    = crc_reg;
        crc4_next   = crc4_reg;
        rcv_next    = rcv_reg;
        res         = '0;

        if (byte_count_reg == 11'd0)
        begin
            if (rx_byte == sync_byte)
            begin
                byte_count_next = 11'd1;
                type_next = '0; length_next = '0; eaf_next = 1'b0; crct_next = '0;
                tt_next = 1'b0; sub_next = '0; sol_next = '0; proc_next = '0;
                enc_next = '0; seq_next = '0; ai_next = '0; eal_next = '0;
                time_next = '0; crc_next = '0; crc4_next = '0; rcv_next = '0;
            end
        end
        else
        begin
            byte_count_next = n;
            shift_next = hs[34:0];
            if (n <= auth_end)
                crc_next = crc24_byte(crc_reg, rx_byte);
            if (n <= 11'd3)
            begin
                crc4_next = crc4_byte(crc4_reg, rx_byte);
            end
            else if (n == 11'd4)
            begin
                type_next   = hs[23:17];
                length_next = hs[16:7];
                eaf_next    = hs[6];
                crct_next   = hs[5:4];
                if (crc4_byte(crc4_reg, {rx_byte[7:4], 4'd0}) != rx_byte[3:0])
                begin
                    res.event_res      = EV_HDR_FAIL;
                    res.msg_type       = hs[23:17];
                    res.payload_length = hs[16:7];
                    res.encrypted      = hs[6];
                    byte_count_next    = 11'd0;
                end
            end
            else if (n == 11'd5)
            begin
                sub_next = hs[7:4];
                tt_next  = hs[3];
            end
            else if (n == hdr_end)
            begin
                time_next = tt_reg ? hs[42:11] : {16'd0, hs[26:11]};
                sol_next  = hs[10:4];
                proc_next = hs[3:0];
            end
            else if (eaf_reg && n == ea_end)
            begin
                enc_next = hs[15:12];
                seq_next = hs[11:6];
                ai_next  = hs[5:3];
                eal_next = hs[2:0];
            end
            else if (n > ea_end && n <= pay_end)
            begin
                res.event_res    = EV_PAYLOAD;
                res.payload_byte = rx_byte;
            end
            else if (n > auth_end)
            begin
                rcv_next = {rcv_reg[15:0], rx_byte};
                if (n >= crc_end)
                begin
                    if (crct_reg == CRC_TYPE_24)
                        res.event_res = (rcv_next == crc_reg) ? EV_CRC_OK : EV_CRC_BAD;
                    else
                        res.event_res = EV_UNCHECK;
                    res.msg_type        = type_reg;
                    res.message_subtype = sub_reg;
                    res.payload_length  = length_reg;
                    res.time_tag        = time_reg;
                    res.long_time_tag   = tt_reg;
                    res.soln_ident      = sol_reg;
                    res.processor_id    = proc_reg;
                    res.encrypted       = eaf_reg;
                    res.enc_ident       = enc_reg;
                    res.sequence_number = seq_reg;
                    byte_count_next     = 11'd0;
                end
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_count_reg <= '0;
        else if (take)
            byte_count_reg <= byte_count_next;
    end

    // Frame registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= '0;          type_reg <= '0;          length_reg <= '0;
            eaf_reg    <= 1'b0;        crct_reg <= '0;          tt_reg <= 1'b0;
            sub_reg    <= '0;          sol_reg <= '0;           proc_reg <= '0;
            enc_reg    <= '0;          seq_reg <= '0;           ai_reg <= '0;
            eal_reg    <= '0;          time_reg <= '0;          crc_reg <= '0;
            crc4_reg   <= '0;          rcv_reg <= '0;
        end
        else if (take)
        begin
            shift_reg  <= shift_next;  type_reg <= type_next;   length_reg <= length_next;
            eaf_reg    <= eaf_next;    crct_reg <= crct_next;   tt_reg <= tt_next;
            sub_reg    <= sub_next;    sol_reg <= sol_next;     proc_reg <= proc_next;
            enc_reg    <= enc_next;    seq_reg <= seq_next;     ai_reg <= ai_next;
            eal_reg    <= eal_next;    time_reg <= time_next;   crc_reg <= crc_next;
            crc4_reg   <= crc4_next;   rcv_reg <= rcv_next;
        end
    end

    a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        take && (res.event_res == EV_HDR_FAIL || res.event_res == EV_CRC_OK ||
                 res.event_res == EV_CRC_BAD || res.event_res == EV_UNCHECK)
        |=> byte_count_reg == 11'd0)
        else $error("frame end did not return to hunting");

    a_hunt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg == 11'd0 |-> res.event_res == EV_NONE)
        else $error("event reported while hunting");

    a_payload_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res.event_res == EV_PAYLOAD |-> byte_count_reg >= 11'd6)
        else $error("payload byte inside header");

endmodule

// ----- design/spfp_queue.sv -----
// Back end: short result queue between the parser and the result port.
// Depends on spfp_pkg.
`timescale 1ns / 1ps

module spfp_queue
    import spfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  result_t wr_data,
    input  logic    rd_en,
    output logic    full,
    output logic    empty,
    output result_t rd_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    result_t       mem [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          push_ok, pop_ok;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = wr_en && !full;
    assign pop_ok  = rd_en && !empty;
    assign rd_data = mem[rp_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push_ok && !pop_ok)
            count_next = count_reg + CW'(1);
        else if (pop_ok && !push_ok)
            count_next = count_reg - CW'(1);
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push_ok)
                wp_reg <= (wp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + PW'(1);
            if (pop_ok)
                rp_reg <= (rp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + PW'(1);
            count_reg <= count_next;
        end
    end

    // Store request
    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem[wp_reg] <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue overfilled");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok && !pop_ok |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push lost");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok && !push_ok |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop lost");

endmodule

// ----- design/spartn_frame_parser.sv -----
// Top level of the SPARTN frame parser: sync register, parser front end, result queue.
// Depends on spfp_pkg, spfp_front and spfp_queue.
// Throughput: one byte per cycle while the queue is not full; every accepted byte yields exactly one result.
// A result enters the result queue when its byte is taken and shows on the result ports once it is at the queue head.
// The two-entry result queue lets input continue while a result waits to be popped.
// Reset (rst_n low, asynchronous): hunting for the preamble, queue empty, sync byte 115.
`timescale 1ns / 1ps

module spartn_frame_parser
    import spfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  event_res,
    output logic [7:0]  payload_byte,
    output logic [6:0]  msg_type,
    output logic [3:0]  message_subtype,
    output logic [9:0]  payload_length,
    output logic [31:0] time_tag,
    output logic        long_time_tag,
    output logic [6:0]  soln_ident,
    output logic [3:0]  processor_id,
    output logic        encrypted,
    output logic [3:0]  enc_ident,
    output logic [5:0]  sequence_number,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic [7:0] sync_reg;
    logic       take;
    result_t    front_res, head;

    assign cfg_ready = 1'b1;
    assign take      = push && !full;

    // Hold the preamble value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sync_reg <= SYNC_RESET;
        else if (cfg_valid && cfg_ready)
            sync_reg <= cfg_data;
    end

    spfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx_byte),
        .sync_byte (sync_reg),
        .res       (front_res)
    );

    spfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_res),
        .rd_en   (pop),
        .full    (full),
        .empty   (empty),
        .rd_data (head)
    );

    // Drive result ports from the queue head
    assign event_res       = head.event_res;
    assign payload_byte    = head.payload_byte;
    assign msg_type        = head.msg_type;
    assign message_subtype = head.message_subtype;
    assign payload_length  = head.payload_length;
    assign time_tag        = head.time_tag;
    assign long_time_tag   = head.long_time_tag;
    assign soln_ident      = head.soln_ident;
    assign processor_id    = head.processor_id;
    assign encrypted       = head.encrypted;
    assign enc_ident       = head.enc_ident;
    assign sequence_number = head.sequence_number;

endmodule

// ----- verif/tb.sv -----
// Testbench for spartn_frame_parser: byte-stream stimulus with a built-in frame predictor.
// Depends on spfp_pkg (event codes, result_t) and the spartn_frame_parser RTL.
`timescale 1ns / 1ps

module tb
    import spfp_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  rx_byte;
    logic        empty;
    logic        pop;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [6:0]  msg_type;
    logic [3:0]  message_subtype;
    logic [9:0]  payload_length;
    logic [31:0] time_tag;
    logic        long_time_tag;
    logic [6:0]  soln_ident;
    logic [3:0]  processor_id;
    logic        encrypted;
    logic [3:0]  enc_ident;
    logic [5:0]  sequence_number;
    result_t     res;

    spartn_frame_parser u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .rx_byte(rx_byte),
        .empty(empty), .pop(pop),
        .event_res(event_res), .payload_byte(payload_byte),
        .msg_type(msg_type), .message_subtype(message_subtype),
        .payload_length(payload_length), .time_tag(time_tag),
        .long_time_tag(long_time_tag), .soln_ident(soln_ident),
        .processor_id(processor_id), .encrypted(encrypted),
        .enc_ident(enc_ident), .sequence_number(sequence_number),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    assign res = {event_res, payload_byte, msg_type, message_subtype, payload_length,
                  time_tag, long_time_tag, soln_ident, processor_id, encrypted,
                  enc_ident, sequence_number};

    // Predictor state
    logic [7:0]  p_sync;
    int unsigned p_count;
    logic [63:0] p_shift;
    logic [6:0]  p_type;
    logic [9:0]  p_len;
    logic        p_enc;
    logic [1:0]  p_crct;
    logic        p_tt;
    logic [3:0]  p_sub;
    logic [6:0]  p_sol;
    logic [3:0]  p_proc;
    logic [3:0]  p_encid;
    logic [5:0]  p_seq;
    logic [2:0]  p_ai;
    logic [2:0]  p_eal;
    logic [31:0] p_time;
    logic [23:0] p_crc;
    logic [31:0] p_rxcrc;

    result_t     expected_q[$];
    int          mismatches;
    int          hold_cycles;
    bit          stall_pop;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [23:0] crc24_next(logic [23:0] c, logic [7:0] b);
        logic [24:0] t;
        t = {1'b0, c ^ {b, 16'd0}};
        for (int i = 0; i < 8; i++)
        begin
            t = {t[23:0], 1'b0};
            if (t[24])
                t = t ^ 25'h1864CFB;
        end
        return t[23:0];
    endfunction

    function automatic logic [3:0] crc4_hdr(logic [23:0] bits);
        logic [3:0] c;
        logic       fb;
        c = 4'd0;
        for (int i = 23; i >= 0; i--)
        begin
            fb = c[3] ^ bits[i];
            c  = {c[2:0], 1'b0};
            if (fb)
                c = c ^ 4'h3;
        end
        return c;
    endfunction

    // Field at frame bit position pos, len bits, n frame bytes in
    function automatic logic [31:0] hdr_field(int n, int pos, int len);
        int sh;
        sh = 8 * n - pos - len;
        if (sh < 0 || sh > 63)
            return 32'd0;
        return 32'((p_shift >> sh) & ((64'd1 << len) - 64'd1));
    endfunction

    function automatic int auth_bytes(logic [2:0] code);
        case (code)
            3'd0: return 8;
            3'd1: return 12;
            3'd2: return 16;
            3'd3: return 32;
            3'd4: return 64;
            default: return 0;
        endcase
    endfunction

    function automatic void clear_frame();
        p_shift = '0; p_type = '0; p_len = '0; p_enc = 1'b0; p_crct = '0; p_tt = 1'b0;
        p_sub = '0; p_sol = '0; p_proc = '0; p_encid = '0; p_seq = '0; p_ai = '0;
        p_eal = '0; p_time = '0; p_crc = '0; p_rxcrc = '0;
    endfunction

    // Work out the result that one byte causes and advance the parser state
    function automatic result_t parse_byte(logic [7:0] b);
        result_t r;
        int n, hdr_end, ea_end, pay_end, auth_end, crc_end, tb;
        logic [23:0] h;
        r = '0;
        if (p_count == 0)
        begin
            if (b == p_sync)
            begin
                clear_frame();
                p_count = 1;
            end
            return r;
        end
        n = p_count + 1;
        p_count = n;
        p_shift = {p_shift[55:0], b};
        if (n <= 4)
        begin
            p_crc = crc24_next(p_crc, b);
            if (n == 4)
            begin
                h = p_shift[23:0];
                p_type = 7'(hdr_field(4, 8, 7));
                p_len = 10'(hdr_field(4, 15, 10));
                p_enc = 1'(hdr_field(4, 25, 1));
                p_crct = 2'(hdr_field(4, 26, 2));
                if (crc4_hdr({h[23:4], 4'd0}) != h[3:0])
                begin
                    r.event_res = EV_HDR_FAIL;
                    r.msg_type = p_type;
                    r.payload_length = p_len;
                    r.encrypted = p_enc;
                    p_count = 0;
                end
            end
            return r;
        end
        if (n == 5)
        begin
            p_crc = crc24_next(p_crc, b);
            p_sub = 4'(hdr_field(5, 32, 4));
            p_tt = 1'(hdr_field(5, 36, 1));
            return r;
        end
        tb = p_tt ? 32 : 16;
        hdr_end = 6 + (p_tt ? 4 : 2);
        ea_end = hdr_end + (p_enc ? 2 : 0);
        pay_end = ea_end + p_len;
        auth_end = pay_end + ((p_enc && p_ai > 1) ? auth_bytes(p_eal) : 0);
        crc_end = auth_end + p_crct + 1;
        if (n <= auth_end)
            p_crc = crc24_next(p_crc, b);
        if (n == hdr_end)
        begin
            p_time = hdr_field(n, 37, tb);
            p_sol = 7'(hdr_field(n, 37 + tb, 7));
            p_proc = 4'(hdr_field(n, 44 + tb, 4));
        end
        else if (p_enc && n == ea_end)
        begin
            p_encid = 4'(hdr_field(n, 48 + tb, 4));
            p_seq = 6'(hdr_field(n, 52 + tb, 6));
            p_ai = 3'(hdr_field(n, 58 + tb, 3));
            p_eal = 3'(hdr_field(n, 61 + tb, 3));
        end
        else if (n > ea_end && n <= pay_end)
        begin
            r.event_res = EV_PAYLOAD;
            r.payload_byte = b;
        end
        else if (n > auth_end)
        begin
            p_rxcrc = {p_rxcrc[23:0], b};
            if (n >= crc_end)
            begin
                if (p_crct == CRC_TYPE_24)
                    r.event_res = (p_rxcrc[23:0] == p_crc) ? EV_CRC_OK : EV_CRC_BAD;
                else
                    r.event_res = EV_UNCHECK;
                r.msg_type = p_type;
                r.message_subtype = p_sub;
                r.payload_length = p_len;
                r.time_tag = p_time;
                r.long_time_tag = p_tt;
                r.soln_ident = p_sol;
                r.processor_id = p_proc;
                r.encrypted = p_enc;
                r.enc_ident = p_encid;
                r.sequence_number = p_seq;
                p_count = 0;
            end
        end
        return r;
    endfunction

    // Offer one byte, with a random gap first, until the block takes it
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_q.push_back(parse_byte(b));
    endtask

    task automatic drain();
        int limit;
        limit = 0;
        push <= 1'b0;
        while (expected_q.size() != 0 && limit < 100000)
        begin
            @(posedge clk);
            limit++;
        end
        repeat (5) @(posedge clk);
    endtask

    task automatic write_sync(logic [7:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        p_sync = v;
    endtask

    // Build one frame; bad_hdr corrupts the header check, bad_crc the trailing CRC
    task automatic send_frame(logic [6:0] mtype, int len, logic enc, logic [1:0] crct,
                              logic tt, logic [2:0] ai, logic [2:0] eal,
                              bit bad_hdr, bit bad_crc);
        logic [7:0]  fr[$];
        logic [23:0] h;
        logic [23:0] c;
        logic [63:0] bits;
        int nbits, extra;
        h = {mtype, 10'(len), enc, crct, 4'd0};
        h[3:0] = crc4_hdr({h[23:4], 4'd0}) ^ (bad_hdr ? 4'($urandom_range(1, 15)) : 4'd0);
        fr.push_back(h[23:16]); fr.push_back(h[15:8]); fr.push_back(h[7:0]);
        // subtype, time tag type, tag, solution, processor (+ encryption block)
        bits = {32'($urandom()), 32'($urandom())};
        bits[63:60] = 4'($urandom_range(0, 15));
        bits[59] = tt;
        nbits = tt ? 48 : 32;
        if (enc)
            nbits += 16;
        for (int i = 0; i < nbits / 8; i++)
            fr.push_back(bits[63 - 8 * i -: 8]);
        if (enc)
        begin
            fr[fr.size() - 1][5:3] = ai;
            fr[fr.size() - 1][2:0] = eal;
        end
        for (int i = 0; i < len; i++)
            fr.push_back(8'($urandom_range(0, 255)));
        extra = (enc && ai > 1) ? auth_bytes(eal) : 0;
        for (int i = 0; i < extra; i++)
            fr.push_back(8'($urandom_range(0, 255)));
        c = '0;
        foreach (fr[i])
            c = crc24_next(c, fr[i]);
        if (bad_crc)
            c ^= 24'($urandom_range(1, 255));
        for (int i = crct; i >= 0; i--)
            fr.push_back((i > 2) ? 8'($urandom_range(0, 255)) : c[8 * i +: 8]);
        send_byte(p_sync);
        foreach (fr[i])
            send_byte(fr[i]);
    endtask

    task automatic random_frame();
        send_frame(7'($urandom_range(0, 127)),
                   ($urandom_range(0, 19) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 6),
                   1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)),
                   3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   $urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0);
    endtask

    task automatic test_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(7'd0, 2, 1'b0, CRC_TYPE_24, 1'b0, 3'd0, 3'd0, 1'b0, 1'b0);
        send_frame(7'd127, 1, 1'b1, CRC_TYPE_24, 1'b1, 3'd2, 3'd0, 1'b0, 1'b1);
        send_frame(7'd5, 0, 1'b0, 2'd0, 1'b1, 3'd0, 3'd0, 1'b0, 1'b0);
        send_frame(7'd9, 1, 1'b0, 2'd3, 1'b0, 3'd0, 3'd0, 1'b0, 1'b0);
        send_frame(7'd3, 1, 1'b0, 2'd1, 1'b0, 3'd0, 3'd0, 1'b1, 1'b0);
        send_frame(7'd3, 1, 1'b1, CRC_TYPE_24, 1'b0, 3'd7, 3'd6, 1'b0, 1'b0);
    endtask

    task automatic test_random_frames();
        for (int i = 0; i < 13; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            random_frame();
        end
    endtask

    // Hold the receiver off long enough for the queue to fill and stall input
    task automatic test_backpressure();
        hold_cycles = 60;
        repeat (10) send_byte(8'($urandom_range(0, 255)));
        random_frame();
    endtask

    task automatic test_sync_values();
        write_sync(8'h00);
        random_frame();
        repeat (8) send_byte(8'h00);
        write_sync(8'hFF);
        random_frame();
        random_frame();
        write_sync(SYNC_RESET);
        random_frame();
    endtask

    // Stall the receiver at random, and hold it off when asked
    initial
    begin
        pop = 1'b0;
        stall_pop = 0;
        hold_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else if (stall_pop)
                pop <= ($urandom_range(0, 3) != 0);
            else
                pop <= 1'b1;
            if ($urandom_range(0, 49) == 0)
                stall_pop = !stall_pop;
        end
    end

    // Check each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %p", res);
            end
            else if (res !== expected_q[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %p, actual %p", expected_q[0], res);
                void'(expected_q.pop_front());
            end
            else
                void'(expected_q.pop_front());
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        rx_byte = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        p_sync = SYNC_RESET;
        p_count = 0;
        clear_frame();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_frames();
        test_sync_values();
        drain();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end
endmodule
